// ----- sv/pfp_pkg.sv -----
// Shared types and constants for the parallel flash programmer.
`default_nettype none

package pfp_pkg;

  // Kinds of result transactions.
  typedef enum logic [2:0] {
    K_WRITE = 3'd0,
    K_READ  = 3'd1,
    K_HOST  = 3'd2,
    K_ON    = 3'd3,
    K_OFF   = 3'd4
  } kind_t;

  // Front-end phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ID     = 3'd1,
    PH_ERASE  = 3'd2,
    PH_HDR_R  = 3'd3,
    PH_HDR_W  = 3'd4,
    PH_STREAM = 3'd5,
    PH_WDATA  = 3'd6,
    PH_WPOLL  = 3'd7
  } phase_t;

  // Jobs handed from the front end to the back end.
  typedef enum logic [3:0] {
    OP_ID_START    = 4'd0,
    OP_ERASE_START = 4'd1,
    OP_ON_OFF      = 4'd2,
    OP_ON_READ     = 4'd3,
    OP_ON_UNLOCK   = 4'd4,
    OP_WRITE_READ  = 4'd5,
    OP_WORD_READ   = 4'd6,
    OP_WORD_OFF    = 4'd7,
    OP_ZERO_OFF    = 4'd8,
    OP_READ_ONE    = 4'd9,
    OP_OFF_ONE     = 4'd10,
    OP_UNLOCK      = 4'd11
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [19:0] addr;
    logic [31:0] word;
  } desc_t;

  typedef struct packed {
    kind_t       kind;
    logic [19:0] address;
    logic [31:0] write_data;
    logic [3:0]  lane_mask;
    logic [7:0]  tx_byte;
    logic        last;
  } res_t;

  // Queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Flash command addresses and bytes.
  localparam logic [19:0] ADDR_5555 = 20'h05555;
  localparam logic [19:0] ADDR_2AAA = 20'h02aaa;
  localparam logic [19:0] ADDR_ZERO = 20'h00000;
  localparam logic [19:0] ADDR_ONE  = 20'h00001;
  localparam logic [7:0]  CMD_AA    = 8'haa;
  localparam logic [7:0]  CMD_55    = 8'h55;
  localparam logic [7:0]  CMD_ID    = 8'h90;
  localparam logic [7:0]  CMD_ERASE = 8'h80;
  localparam logic [7:0]  CMD_CHIP  = 8'h10;
  localparam logic [7:0]  CMD_PROG  = 8'ha0;
  localparam logic [3:0]  MASK_CMD  = 4'h5;
  localparam logic [3:0]  MASK_WORD = 4'hf;

  // Host command letters.
  localparam logic [7:0] CH_ID    = 8'h69;
  localparam logic [7:0] CH_ERASE = 8'h65;
  localparam logic [7:0] CH_READ  = 8'h72;
  localparam logic [7:0] CH_WRITE = 8'h77;

endpackage

`default_nettype wire

// ----- sv/parallel_flash_programmer.sv -----
// Top level of the parallel flash programmer: front end, job queue and back end.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    cmd, host_byte, bus_read_data
//   out_     output     out_valid/out_stall  kind, address, write_data, lane_mask,
//                                            tx_byte, last
//
// The front end takes one input transaction per cycle while in_stall is low and decides
// its job in that cycle. The back end sends one result per cycle while a job is queued
// and out_stall is low; a job has one to eight results; the four-entry queue sets
// how far the front end may run ahead. With the queue empty, a result follows its input
// through the queue entry and the output register. Reset is synchronous, with no clearing
// pass. in_stall rises only while the job queue is full; out_stall freezes a valid result.
`default_nettype none

module parallel_flash_programmer #(
  parameter int ADDRESS_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_host_byte,
  input  wire logic [31:0] in_bus_read_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [19:0]      out_address,
  output logic [31:0]      out_write_data,
  output logic [3:0]       out_lane_mask,
  output logic [7:0]       out_tx_byte,
  output logic             out_last
);

  pfp_pkg::desc_t push_desc;
  pfp_pkg::desc_t head;
  pfp_pkg::res_t  res;
  logic           push;
  logic           pop;
  logic           full;
  logic           head_valid;
  logic           accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  pfp_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cmd          (in_cmd),
    .host_byte    (in_host_byte),
    .bus_read_data(in_bus_read_data),
    .push_desc    (push_desc),
    .push         (push)
  );

  pfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  pfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  // Result fields to ports.
  assign out_kind       = res.kind;
  assign out_address    = res.address;
  assign out_write_data = res.write_data;
  assign out_lane_mask  = res.lane_mask;
  assign out_tx_byte    = res.tx_byte;
  assign out_last       = res.last;

endmodule

`default_nettype wire

// ----- sv/pfp_front.sv -----
// Front end: accepts input transactions, tracks the command phase and queues jobs.
`default_nettype none

module pfp_front #(
  parameter int ADDRESS_BITS = 20
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic           cmd,
  input  wire logic [7:0]     host_byte,
  input  wire logic [31:0]    bus_read_data,
  output pfp_pkg::desc_t      push_desc,
  output logic                push
);

  localparam logic [31:0] AMASK = 32'((64'd1 << ADDRESS_BITS) - 64'd1);

  pfp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] header_shift_r, header_shift_nxt;
  logic [2:0]  byte_index_r, byte_index_nxt;
  logic [31:0] word_address_r, word_address_nxt;
  logic [31:0] words_left_r, words_left_nxt;
  logic [23:0] data_assembly_r, data_assembly_nxt;
  logic [1:0]  expected_bits_r, expected_bits_nxt;
  logic        id_step_r, id_step_nxt;

  logic [31:0] hs_n;
  logic [31:0] wa_n;
  logic [31:0] wl_n;
  logic [31:0] full_word;
  logic        poll_ok;

  function automatic logic [19:0] baddr(input logic [31:0] a);
    logic [31:0] m;
    m = a & AMASK;
    return m[19:0];
  endfunction

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= pfp_pkg::PH_IDLE;
      header_shift_r  <= '0;
      byte_index_r    <= '0;
      word_address_r  <= '0;
      words_left_r    <= '0;
      data_assembly_r <= '0;
      expected_bits_r <= '0;
      id_step_r       <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      header_shift_r  <= header_shift_nxt;
      byte_index_r    <= byte_index_nxt;
      word_address_r  <= word_address_nxt;
      words_left_r    <= words_left_nxt;
      data_assembly_r <= data_assembly_nxt;
      expected_bits_r <= expected_bits_nxt;
      id_step_r       <= id_step_nxt;
    end
  end

  // Datapath helpers, most shared by several phases.
  assign hs_n      = {host_byte, header_shift_r[31:8]};
  assign wl_n      = words_left_r - 32'd1;
  assign wa_n      = word_address_r + 32'd1;
  assign full_word = {host_byte, data_assembly_r};
  assign poll_ok   = (bus_read_data[7] == expected_bits_r[0]) &&
                     (bus_read_data[23] == expected_bits_r[1]);

  // Next phase and the job, if any, for each accepted transaction.
  always_comb begin
    phase_nxt         = phase_r;
    header_shift_nxt  = header_shift_r;
    byte_index_nxt    = byte_index_r;
    word_address_nxt  = word_address_r;
    words_left_nxt    = words_left_r;
    data_assembly_nxt = data_assembly_r;
    expected_bits_nxt = expected_bits_r;
    id_step_nxt       = id_step_r;
    push              = 1'b0;
    push_desc.op      = pfp_pkg::OP_OFF_ONE;
    push_desc.addr    = '0;
    push_desc.word    = '0;
    if (accept && !cmd) begin
      // Host byte.
      unique case (phase_r)
        pfp_pkg::PH_IDLE: begin
          if (host_byte == pfp_pkg::CH_ID) begin
            push           = 1'b1;
            push_desc.op   = pfp_pkg::OP_ID_START;
            push_desc.addr = pfp_pkg::ADDR_ZERO;
            id_step_nxt    = 1'b0;
            phase_nxt      = pfp_pkg::PH_ID;
          end else if (host_byte == pfp_pkg::CH_ERASE) begin
            push              = 1'b1;
            push_desc.op      = pfp_pkg::OP_ERASE_START;
            expected_bits_nxt = 2'b11;
            phase_nxt         = pfp_pkg::PH_ERASE;
          end else if (host_byte == pfp_pkg::CH_READ || host_byte == pfp_pkg::CH_WRITE) begin
            phase_nxt        = (host_byte == pfp_pkg::CH_READ) ? pfp_pkg::PH_HDR_R
                                                               : pfp_pkg::PH_HDR_W;
            byte_index_nxt   = '0;
            header_shift_nxt = '0;
          end
        end
        pfp_pkg::PH_HDR_R, pfp_pkg::PH_HDR_W: begin
          header_shift_nxt = hs_n;
          if (byte_index_r == 3'd3) begin
            word_address_nxt = hs_n;
          end
          if (byte_index_r != 3'd7) begin
            byte_index_nxt = byte_index_r + 3'd1;
          end else begin
            byte_index_nxt = '0;
            words_left_nxt = hs_n;
            push           = 1'b1;
            if (hs_n == 32'd0) begin
              push_desc.op = pfp_pkg::OP_ON_OFF;
              phase_nxt    = pfp_pkg::PH_IDLE;
            end else if (phase_r == pfp_pkg::PH_HDR_R) begin
              push_desc.op   = pfp_pkg::OP_ON_READ;
              push_desc.addr = baddr(word_address_r);
              phase_nxt      = pfp_pkg::PH_STREAM;
            end else begin
              push_desc.op      = pfp_pkg::OP_ON_UNLOCK;
              data_assembly_nxt = '0;
              phase_nxt         = pfp_pkg::PH_WDATA;
            end
          end
        end
        pfp_pkg::PH_WDATA: begin
          unique case (byte_index_r[1:0])
            2'd0: data_assembly_nxt = data_assembly_r | {16'd0, host_byte};
            2'd1: data_assembly_nxt = data_assembly_r | {8'd0, host_byte, 8'd0};
            2'd2: data_assembly_nxt = data_assembly_r | {host_byte, 16'd0};
            default: data_assembly_nxt = data_assembly_r;
          endcase
          if (byte_index_r[1:0] != 2'd3) begin
            byte_index_nxt = byte_index_r + 3'd1;
          end else begin
            byte_index_nxt    = '0;
            expected_bits_nxt = {full_word[23], full_word[7]};
            push              = 1'b1;
            push_desc.op      = pfp_pkg::OP_WRITE_READ;
            push_desc.addr    = baddr(word_address_r);
            push_desc.word    = full_word;
            phase_nxt         = pfp_pkg::PH_WPOLL;
          end
        end
        default: begin
        end
      endcase
    end else if (accept && cmd) begin
      // Bus read word.
      unique case (phase_r)
        pfp_pkg::PH_ID: begin
          push           = 1'b1;
          push_desc.word = bus_read_data;
          push_desc.addr = pfp_pkg::ADDR_ONE;
          if (!id_step_r) begin
            push_desc.op = pfp_pkg::OP_WORD_READ;
            id_step_nxt  = 1'b1;
          end else begin
            push_desc.op = pfp_pkg::OP_WORD_OFF;
            id_step_nxt  = 1'b0;
            phase_nxt    = pfp_pkg::PH_IDLE;
          end
        end
        pfp_pkg::PH_ERASE: begin
          push = 1'b1;
          if (poll_ok) begin
            push_desc.op = pfp_pkg::OP_ZERO_OFF;
            phase_nxt    = pfp_pkg::PH_IDLE;
          end else begin
            push_desc.op   = pfp_pkg::OP_READ_ONE;
            push_desc.addr = pfp_pkg::ADDR_5555;
          end
        end
        pfp_pkg::PH_STREAM: begin
          push             = 1'b1;
          push_desc.word   = bus_read_data;
          words_left_nxt   = wl_n;
          word_address_nxt = wa_n;
          if (wl_n == 32'd0) begin
            push_desc.op = pfp_pkg::OP_WORD_OFF;
            phase_nxt    = pfp_pkg::PH_IDLE;
          end else begin
            push_desc.op   = pfp_pkg::OP_WORD_READ;
            push_desc.addr = baddr(wa_n);
          end
        end
        pfp_pkg::PH_WPOLL: begin
          push = 1'b1;
          if (!poll_ok) begin
            push_desc.op   = pfp_pkg::OP_READ_ONE;
            push_desc.addr = baddr(word_address_r);
          end else begin
            words_left_nxt   = wl_n;
            word_address_nxt = wa_n;
            if (wl_n == 32'd0) begin
              push_desc.op = pfp_pkg::OP_OFF_ONE;
              phase_nxt    = pfp_pkg::PH_IDLE;
            end else begin
              push_desc.op      = pfp_pkg::OP_UNLOCK;
              data_assembly_nxt = '0;
              byte_index_nxt    = '0;
              phase_nxt         = pfp_pkg::PH_WDATA;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/pfp_queue.sv -----
// Short job queue between the front end and the back end.
`default_nettype none

module pfp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pfp_pkg::desc_t  push_desc,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output pfp_pkg::desc_t       head
);

  pfp_pkg::desc_t                 entry_r [pfp_pkg::QDEPTH];
  logic [pfp_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [pfp_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [pfp_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count_r == pfp_pkg::QCNT_W'(pfp_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + pfp_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + pfp_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + pfp_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - pfp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pfp_pkg::QCNT_W'(pfp_pkg::QDEPTH))
    else $error("queue fill count exceeds its depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[pfp_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with the fill count");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed while the queue is full");

endmodule

`default_nettype wire

// ----- sv/pfp_back.sv -----
// Back end: expands queued jobs into one result per cycle unless stalled.
`default_nettype none

module pfp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire pfp_pkg::desc_t  head,
  output logic                 pop,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output pfp_pkg::res_t        out_res
);

  logic          mid_job;
  logic [2:0]    idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  pfp_pkg::res_t res_r;
  pfp_pkg::res_t cur;
  logic          load;

  function automatic pfp_pkg::res_t r_blank();
    pfp_pkg::res_t r;
    r.kind       = pfp_pkg::K_OFF;
    r.address    = '0;
    r.write_data = '0;
    r.lane_mask  = '0;
    r.tx_byte    = '0;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic pfp_pkg::res_t r_kind(input pfp_pkg::kind_t k);
    pfp_pkg::res_t r;
    r      = r_blank();
    r.kind = k;
    return r;
  endfunction

  function automatic pfp_pkg::res_t r_read(input logic [19:0] a);
    pfp_pkg::res_t r;
    r         = r_kind(pfp_pkg::K_READ);
    r.address = a;
    return r;
  endfunction

  function automatic pfp_pkg::res_t r_host(input logic [7:0] b);
    pfp_pkg::res_t r;
    r         = r_kind(pfp_pkg::K_HOST);
    r.tx_byte = b;
    return r;
  endfunction

  // One write of an unlock sequence; k counts 0 to 2.
  function automatic pfp_pkg::res_t r_unlock(input logic [2:0] k, input logic [7:0] c);
    pfp_pkg::res_t r;
    logic [7:0]    b;
    r = r_kind(pfp_pkg::K_WRITE);
    if (k == 3'd1) begin
      r.address = pfp_pkg::ADDR_2AAA;
      b         = pfp_pkg::CMD_55;
    end else begin
      r.address = pfp_pkg::ADDR_5555;
      b         = (k == 3'd0) ? pfp_pkg::CMD_AA : c;
    end
    r.write_data = {8'd0, b, 8'd0, b};
    r.lane_mask  = pfp_pkg::MASK_CMD;
    return r;
  endfunction

  function automatic logic [7:0] lane(input logic [31:0] w, input logic [1:0] s);
    logic [7:0] b;
    unique case (s)
      2'd0: b = w[7:0];
      2'd1: b = w[15:8];
      2'd2: b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

  // Result for step s of job d.
  function automatic pfp_pkg::res_t gen(input pfp_pkg::desc_t d, input logic [2:0] s);
    pfp_pkg::res_t r;
    r = r_blank();
    unique case (d.op)
      pfp_pkg::OP_ID_START: begin
        if (s == 3'd0) r = r_kind(pfp_pkg::K_ON);
        else if (s < 3'd4) r = r_unlock(s - 3'd1, pfp_pkg::CMD_ID);
        else begin
          r      = r_read(d.addr);
          r.last = 1'b1;
        end
      end
      pfp_pkg::OP_ERASE_START: begin
        if (s == 3'd0) r = r_kind(pfp_pkg::K_ON);
        else if (s < 3'd4) r = r_unlock(s - 3'd1, pfp_pkg::CMD_ERASE);
        else if (s < 3'd7) r = r_unlock(s - 3'd4, pfp_pkg::CMD_CHIP);
        else begin
          r      = r_read(pfp_pkg::ADDR_5555);
          r.last = 1'b1;
        end
      end
      pfp_pkg::OP_ON_OFF: begin
        if (s == 3'd0) r = r_kind(pfp_pkg::K_ON);
        else begin
          r      = r_kind(pfp_pkg::K_OFF);
          r.last = 1'b1;
        end
      end
      pfp_pkg::OP_ON_READ: begin
        if (s == 3'd0) r = r_kind(pfp_pkg::K_ON);
        else begin
          r      = r_read(d.addr);
          r.last = 1'b1;
        end
      end
      pfp_pkg::OP_ON_UNLOCK: begin
        if (s == 3'd0) r = r_kind(pfp_pkg::K_ON);
        else begin
          r      = r_unlock(s - 3'd1, pfp_pkg::CMD_PROG);
          r.last = (s == 3'd3);
        end
      end
      pfp_pkg::OP_WRITE_READ: begin
        if (s == 3'd0) begin
          r            = r_kind(pfp_pkg::K_WRITE);
          r.address    = d.addr;
          r.write_data = d.word;
          r.lane_mask  = pfp_pkg::MASK_WORD;
        end else begin
          r      = r_read(d.addr);
          r.last = 1'b1;
        end
      end
      pfp_pkg::OP_WORD_READ: begin
        if (s < 3'd4) r = r_host(lane(d.word, s[1:0]));
        else begin
          r      = r_read(d.addr);
          r.last = 1'b1;
        end
      end
      pfp_pkg::OP_WORD_OFF: begin
        if (s < 3'd4) r = r_host(lane(d.word, s[1:0]));
        else begin
          r      = r_kind(pfp_pkg::K_OFF);
          r.last = 1'b1;
        end
      end
      pfp_pkg::OP_ZERO_OFF: begin
        if (s == 3'd0) r = r_host(8'd0);
        else begin
          r      = r_kind(pfp_pkg::K_OFF);
          r.last = 1'b1;
        end
      end
      pfp_pkg::OP_READ_ONE: begin
        r      = r_read(d.addr);
        r.last = 1'b1;
      end
      pfp_pkg::OP_UNLOCK: begin
        r      = r_unlock(s, pfp_pkg::CMD_PROG);
        r.last = (s == 3'd2);
      end
      default: begin
        r      = r_kind(pfp_pkg::K_OFF);
        r.last = 1'b1;
      end
    endcase
    return r;
  endfunction

  assign mid_job    = (idx_r != 3'd0);
  assign cur        = gen(head, idx_r);
  assign load       = !out_valid_r || !out_stall;
  assign pop        = load && head_valid && cur.last;
  assign out_valid  = out_valid_r;
  assign out_res    = res_r;

  // Step counter and output register control.
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        idx_nxt = cur.last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      res_r <= cur;
    end
  end

  a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
    mid_job |-> head_valid)
    else $error("job left the queue before all its results were sent");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 3'd0))
    else $error("step counter did not restart after a job ended");

  a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && head_valid) |=> (out_res.last == (idx_r == 3'd0)))
    else $error("last flag disagrees with the step counter");

endmodule

`default_nettype wire
